// ----- rtl/hdr_half_float_to_srgb8_pixel_assert.svh -----
// Assertion macros used by the top-level pixel converter.
`ifndef HDR_HALF_FLOAT_TO_SRGB8_PIXEL_ASSERT_SVH
`define HDR_HALF_FLOAT_TO_SRGB8_PIXEL_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define HFS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Condition that must hold whenever a trigger is seen.
`define HFS_ASSERT_IMPLY(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

`endif

// ----- rtl/hfs_pkg.sv -----
// Shared types, constants and threshold functions for the pixel converter.
package hfs_pkg;

	localparam int LINEAR_FRAC_BITS_DEF = 16;
	localparam int CODE_W               = 16;
	localparam int BYTE_W               = 8;
	localparam int GAIN_W               = 17;
	localparam int HALF_MANT_W          = 11;
	localparam int CFG_IDX_W            = 8;
	localparam int SRGB_STAGES          = 8;
	localparam int NUM_LANES            = 3;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd26214;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FLOAT_INPUT = 8'd0,
		CFG_WHITE_GAIN  = 8'd1
	} cfg_idx_t;

	typedef struct packed {
		logic [CODE_W-1:0] red_code;
		logic [CODE_W-1:0] green_code;
		logic [CODE_W-1:0] blue_code;
	} in_pixel_t;

	typedef struct packed {
		logic [BYTE_W-1:0] red_byte;
		logic [BYTE_W-1:0] green_byte;
		logic [BYTE_W-1:0] blue_byte;
	} out_pixel_t;

	// Result known early (byte mode, zero, NaN, infinity, negatives).
	typedef struct packed {
		logic              fixed;
		logic [BYTE_W-1:0] val;
	} lane_side_t;

	// Exact test: linear t / 2^fb reaches the decision point of byte k (k > 10).
	function automatic logic srgb_reaches(input logic [31:0] t, input int k, input int fb);
		logic [383:0] a;
		logic [383:0] b;
		a = 384'd1;
		for (int i = 0; i < 5; i++) a = a * 384'(t);
		for (int i = 0; i < 12; i++) a = a * 384'(10761);
		b = 384'd1;
		for (int i = 0; i < 12; i++) b = b * 384'(40 * k + 541);
		b = b << (5 * fb);
		return a >= b;
	endfunction

	// Smallest linear code that encodes to byte k or above.
	function automatic logic [31:0] srgb_thresh(input int k, input int fb);
		longint      num;
		logic [31:0] t;
		real         r;
		if (k == 0) return 32'd0;
		if (k <= 10) begin
			num = longint'((2 * k - 1) * 100) << fb;
			return 32'((num + 64'd658919) / 64'd658920);
		end
		r = (real'(40 * k + 541) / 10761.0) ** 2.4;
		r = r * (2.0 ** fb);
		t = 32'($rtoi(r));
		for (int i = 0; i < 4; i++)
			if (!srgb_reaches(t, k, fb)) t = t + 32'd1;
		for (int i = 0; i < 4; i++)
			if (t != 32'd0 && srgb_reaches(t - 32'd1, k, fb)) t = t - 32'd1;
		return t;
	endfunction

endpackage

// ----- rtl/hfs_tone.sv -----
// Per-channel front end: half decode, white gain, highlight roll-off divider.
module hfs_tone import hfs_pkg::*; #(
	parameter int LINEAR_FRAC_BITS = LINEAR_FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic [CODE_W-1:0]           code,
	input  logic                        float_input,
	input  logic [GAIN_W-1:0]           white_gain,
	output logic [LINEAR_FRAC_BITS:0]   y,
	output lane_side_t                  side
);
	localparam int F  = LINEAR_FRAC_BITS;
	localparam int PW = GAIN_W + HALF_MANT_W;
	localparam int SW = PW + F;
	localparam int XW = F + 17;
	localparam int NW = 2 * F + 18;
	localparam int DW = F + 23;
	localparam int QB = F - 5;
	localparam int TW = F + 1;

	logic                   sign;
	logic [4:0]             expo;
	logic [9:0]             frac;
	logic [HALF_MANT_W-1:0] mant;
	logic [4:0]             eff;
	lane_side_t             side_d;

	logic [PW-1:0] prod_s1;
	logic [4:0]    eff_s1;
	lane_side_t    side_s1;

	logic [SW-1:0] shifted;
	logic [XW-1:0] x_s2;
	lane_side_t    side_s2;

	logic [NW-1:0] n_s3;
	logic [DW-1:0] d_s3;
	logic          big_s3;
	logic [TW-1:0] xl_s3;
	lane_side_t    side_s3;

	logic [NW-1:0] rem_in  [QB];
	logic [QB-1:0] q_in    [QB];
	logic [DW-1:0] d_in    [QB];
	logic          big_in  [QB];
	logic [TW-1:0] xl_in   [QB];
	lane_side_t    side_in [QB];

	logic [NW-1:0] rem_sd  [QB];
	logic [QB-1:0] q_sd    [QB];
	logic [DW-1:0] d_sd    [QB];
	logic          big_sd  [QB];
	logic [TW-1:0] xl_sd   [QB];
	lane_side_t    side_sd [QB];

	assign sign = code[15];
	assign expo = code[14:10];
	assign frac = code[9:0];
	assign mant = (expo == 5'd0) ? {1'b0, frac} : {1'b1, frac};
	assign eff  = (expo == 5'd0) ? 5'd1 : expo;

	always_comb begin
		side_d = '{fixed: 1'b0, val: '0};
		if (!float_input) begin
			side_d = '{fixed: 1'b1, val: code[BYTE_W-1:0]};
		end else if (expo == 5'd31) begin
			side_d.fixed = 1'b1;
			side_d.val   = (frac == 10'd0 && !sign) ? 8'hFF : 8'h00;
		end else if (sign || (expo == 5'd0 && frac == 10'd0)) begin
			side_d.fixed = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(mant) * PW'(white_gain);
		eff_s1  <= eff;
		side_s1 <= side_d;
	end

	// value = prod * 2^(eff - 41 + F), truncated
	assign shifted = {prod_s1, {F{1'b0}}} >> (6'd41 - {1'b0, eff_s1});

	always_ff @(posedge clk) begin
		x_s2    <= XW'(shifted);
		side_s2 <= side_s1;
	end

	always_ff @(posedge clk) begin
		n_s3    <= (NW'(1) << (2 * F)) + NW'(x_s2) * NW'(25);
		d_s3    <= DW'(x_s2) * DW'(50);
		big_s3  <= x_s2 > (XW'(1) << F);
		xl_s3   <= x_s2[TW-1:0];
		side_s3 <= '{fixed: side_s2.fixed | (x_s2 == '0), val: side_s2.val};
	end

	// restoring divider, one quotient bit per stage
	for (genvar i = 0; i < QB; i++) begin : g_div
		logic [NW-1:0] sub;
		logic          ge;
		if (i == 0) begin : g_first
			assign rem_in[i]  = n_s3;
			assign q_in[i]    = '0;
			assign d_in[i]    = d_s3;
			assign big_in[i]  = big_s3;
			assign xl_in[i]   = xl_s3;
			assign side_in[i] = side_s3;
		end else begin : g_next
			assign rem_in[i]  = rem_sd[i-1];
			assign q_in[i]    = q_sd[i-1];
			assign d_in[i]    = d_sd[i-1];
			assign big_in[i]  = big_sd[i-1];
			assign xl_in[i]   = xl_sd[i-1];
			assign side_in[i] = side_sd[i-1];
		end
		assign sub = NW'(d_in[i]) << (QB - 1 - i);
		assign ge  = rem_in[i] >= sub;
		always_ff @(posedge clk) begin
			rem_sd[i]  <= ge ? rem_in[i] - sub : rem_in[i];
			q_sd[i]    <= q_in[i] | (ge ? (QB'(1) << (QB - 1 - i)) : '0);
			d_sd[i]    <= d_in[i];
			big_sd[i]  <= big_in[i];
			xl_sd[i]   <= xl_in[i];
			side_sd[i] <= side_in[i];
		end
	end

	assign y    = big_sd[QB-1] ? (TW'(1) << F) - TW'(q_sd[QB-1]) : xl_sd[QB-1];
	assign side = side_sd[QB-1];

endmodule

// ----- rtl/hfs_encode.sv -----
// Per-channel sRGB encoder: binary search over the byte decision points.
module hfs_encode import hfs_pkg::*; #(
	parameter int LINEAR_FRAC_BITS = LINEAR_FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic [LINEAR_FRAC_BITS:0] y,
	input  lane_side_t                side,
	output logic [BYTE_W-1:0]         pix_byte
);
	localparam int TW = LINEAR_FRAC_BITS + 1;
	localparam int NT = 1 << SRGB_STAGES;

	typedef logic [TW-1:0] thr_arr_t [NT];

	function automatic thr_arr_t build_thr();
		thr_arr_t t;
		for (int k = 0; k < NT; k++) t[k] = TW'(srgb_thresh(k, LINEAR_FRAC_BITS));
		return t;
	endfunction

	localparam thr_arr_t THRESH = build_thr();

	logic [TW-1:0]          y_in    [SRGB_STAGES];
	logic [SRGB_STAGES-1:0] idx_in  [SRGB_STAGES];
	lane_side_t             side_in [SRGB_STAGES];

	logic [TW-1:0]          y_se    [SRGB_STAGES];
	logic [SRGB_STAGES-1:0] idx_se  [SRGB_STAGES];
	lane_side_t             side_se [SRGB_STAGES];

	// each stage settles one bit of the byte, MSB first
	for (genvar j = 0; j < SRGB_STAGES; j++) begin : g_stage
		logic [SRGB_STAGES-1:0] cand;
		if (j == 0) begin : g_first
			assign y_in[j]    = y;
			assign idx_in[j]  = '0;
			assign side_in[j] = side;
		end else begin : g_next
			assign y_in[j]    = y_se[j-1];
			assign idx_in[j]  = idx_se[j-1];
			assign side_in[j] = side_se[j-1];
		end
		assign cand = idx_in[j] | (SRGB_STAGES'(1) << (SRGB_STAGES - 1 - j));
		always_ff @(posedge clk) begin
			y_se[j]    <= y_in[j];
			idx_se[j]  <= (y_in[j] >= THRESH[cand]) ? cand : idx_in[j];
			side_se[j] <= side_in[j];
		end
	end

	assign pix_byte = side_se[SRGB_STAGES-1].fixed ? side_se[SRGB_STAGES-1].val
	                                               : idx_se[SRGB_STAGES-1];

endmodule

// ----- rtl/hfs_fifo.sv -----
// Result buffer that absorbs every pixel in flight when the sink stalls.
module hfs_fifo import hfs_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr,
	input  out_pixel_t                 wdata,
	input  logic                       rd,
	output out_pixel_t                 rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] cnt
);
	localparam int PTRW = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	out_pixel_t      mem [DEPTH];
	logic [PTRW-1:0] wr_ptr_q;
	logic [PTRW-1:0] rd_ptr_q;
	logic [CNTW-1:0] cnt_q;
	logic            do_rd;

	assign do_rd = rd && (cnt_q != '0);

	always_ff @(posedge clk) begin
		if (wr) mem[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + PTRW'(1);
			if (do_rd) rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + PTRW'(1);
			cnt_q <= cnt_q + CNTW'(wr) - CNTW'(do_rd);
		end
	end

	assign rdata = mem[rd_ptr_q];
	assign empty = (cnt_q == '0);
	assign cnt   = cnt_q;

endmodule

// ----- rtl/hdr_half_float_to_srgb8_pixel.sv -----
// HDR half-float pixel to sRGB byte converter, one pixel per clock. Three identical
// lanes each take one channel through gain scaling, a 1 - 0.02/x highlight roll-off
// (a restoring divider with one quotient bit per stage, LINEAR_FRAC_BITS-5 stages) and
// an 8-stage binary search over the sRGB decision points; the lane bytes are joined
// into one result. A result buffer holds every pixel in flight, so a new pixel is
// accepted every cycle while the sink keeps up; configuration writes are taken at any
// time and must only be issued while the converter is empty.
`include "hdr_half_float_to_srgb8_pixel_assert.svh"

module hdr_half_float_to_srgb8_pixel import hfs_pkg::*; #(
	parameter int LINEAR_FRAC_BITS = LINEAR_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_pixel_t            in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_pixel_t           out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_data
);
	localparam int F        = LINEAR_FRAC_BITS;
	localparam int TONE_LAT = 3 + (F - 5);
	localparam int LAT      = TONE_LAT + SRGB_STAGES;
	localparam int DEPTH    = LAT + 2;
	localparam int CRW      = $clog2(DEPTH + 1);

	logic              float_input_q;
	logic [GAIN_W-1:0] white_gain_q;
	logic [CRW-1:0]    credit_q;
	logic [LAT-1:0]    vld_q;
	logic              in_acc;
	logic              out_acc;
	logic              fifo_empty;
	logic [CRW-1:0]    fifo_cnt;

	logic [CODE_W-1:0] lane_code [NUM_LANES];
	logic [BYTE_W-1:0] lane_byte [NUM_LANES];
	out_pixel_t        merged;

	assign cfg_ready = 1'b1;
	assign in_ready  = credit_q < CRW'(DEPTH);
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			float_input_q <= 1'b1;
			white_gain_q  <= GAIN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FLOAT_INPUT: float_input_q <= cfg_data[0];
				CFG_WHITE_GAIN:  white_gain_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// credits cover pixels in the lanes plus those waiting in the buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
			vld_q    <= '0;
		end else begin
			credit_q <= credit_q + CRW'(in_acc) - CRW'(out_acc);
			vld_q    <= {vld_q[LAT-2:0], in_acc};
		end
	end

	assign lane_code[0] = in_data.red_code;
	assign lane_code[1] = in_data.green_code;
	assign lane_code[2] = in_data.blue_code;

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		logic [F:0] y;
		lane_side_t side;

		hfs_tone #(.LINEAR_FRAC_BITS(F)) u_tone (
			.clk         (clk),
			.code        (lane_code[l]),
			.float_input (float_input_q),
			.white_gain  (white_gain_q),
			.y           (y),
			.side        (side)
		);

		hfs_encode #(.LINEAR_FRAC_BITS(F)) u_encode (
			.clk      (clk),
			.y        (y),
			.side     (side),
			.pix_byte (lane_byte[l])
		);
	end

	assign merged = '{red_byte: lane_byte[0], green_byte: lane_byte[1],
	                  blue_byte: lane_byte[2]};

	hfs_fifo #(.DEPTH(DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (vld_q[LAT-1]),
		.wdata  (merged),
		.rd     (out_ready),
		.rdata  (out_data),
		.empty  (fifo_empty),
		.cnt    (fifo_cnt)
	);

	assign out_valid = !fifo_empty;

	`HFS_ASSERT_ALWAYS(a_credit_bound, credit_q <= CRW'(DEPTH), "credit count above buffer depth")
	`HFS_ASSERT_ALWAYS(a_credit_match, credit_q == CRW'($countones(vld_q)) + fifo_cnt, "credit count lost track of pixels")
	`HFS_ASSERT_IMPLY(a_no_overflow, vld_q[LAT-1], fifo_cnt < CRW'(DEPTH), "result buffer overflow")

endmodule

// ----- tb/testbench.sv -----
// Testbench for the HDR half-float to sRGB byte pixel converter, checked against a local predictor.
`timescale 1ns / 1ps

module testbench;
	import hfs_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_pixel_t            in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_pixel_t           out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [GAIN_W-1:0]    cfg_data = '0;

	hdr_half_float_to_srgb8_pixel uut (.*);

	always #5 clk = ~clk;

	// converter settings as seen by the predictor
	logic              float_mode = 1'b1;
	logic [GAIN_W-1:0] gain = GAIN_RESET;

	out_pixel_t pending_pixels[$];
	int         errors = 0;
	int         idle_in = 0;
	int         idle_out = 0;

	typedef struct {
		logic [CODE_W-1:0] r, g, b;
		bit                typed;
		logic [BYTE_W-1:0] byte_all;
	} stim_row_t;

	stim_row_t directed[] = '{
		'{16'h0000, 16'h8000, 16'h0001, 1'b1, 8'd0},   // +0, -0, tiny subnormal
		'{16'h7C00, 16'h7C00, 16'h7C00, 1'b1, 8'd255}, // +inf
		'{16'hFC00, 16'h8001, 16'hBC00, 1'b1, 8'd0},   // negatives
		'{16'h7E00, 16'h7C01, 16'hFFFF, 1'b1, 8'd0},   // NaN patterns
		'{16'h7BFF, 16'h3C00, 16'h03FF, 1'b0, 8'd0},   // max finite, 1.0, max subnormal
		'{16'h4A00, 16'h4B00, 16'h4A40, 1'b0, 8'd0},   // gained to about 5 linear at reset gain
		'{16'h2000, 16'h1800, 16'h0400, 1'b0, 8'd0},   // linear toe region
		'{16'h3800, 16'h3555, 16'h5640, 1'b0, 8'd0},
		'{16'h0010, 16'h0100, 16'h7800, 1'b0, 8'd0}
	};

	function automatic logic [7:0] encode_srgb(input logic [63:0] y);
		logic [319:0] y5;
		logic [319:0] bound;
		int           lo, hi, mid;
		bit           ok;
		if (y == 0) return 8'd0;
		if (y >= 64'd65536) return 8'd255;
		y5 = 320'd1;
		for (int i = 0; i < 5; i++) y5 = y5 * 320'(y);
		for (int i = 0; i < 12; i++) y5 = y5 * 320'(10761);
		lo = 0;
		hi = 255;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid <= 10) begin
				ok = (y * 64'd658920) >= (64'((2 * mid - 1) * 100) << 16);
			end else begin
				bound = 320'd1;
				for (int i = 0; i < 12; i++) bound = bound * 320'(40 * mid + 541);
				ok = y5 >= (bound << 80);
			end
			if (ok) lo = mid;
			else hi = mid - 1;
		end
		return 8'(lo);
	endfunction

	function automatic logic [7:0] map_channel(input logic [15:0] h);
		logic [4:0]  e;
		logic [9:0]  m;
		logic [63:0] prod, x, q, y;
		int          sh;
		if (!float_mode) return h[7:0];
		e = h[14:10];
		m = h[9:0];
		if (e == 5'd31) return (m == 0 && !h[15]) ? 8'd255 : 8'd0;
		if (h[15] || (e == 0 && m == 0)) return 8'd0;
		if (e == 0) begin
			prod = 64'(m) * 64'(gain);
			sh = 1 - 25;
		end else begin
			prod = 64'({1'b1, m}) * 64'(gain);
			sh = int'(e) - 25;
		end
		x = sh >= 0 ? (prod << sh) : (prod >> (-sh));
		if (x > 64'h1_FFFF_FFFF) x = 64'h1_FFFF_FFFF;
		if (x == 0) return 8'd0;
		if (x > 64'd65536) begin
			q = (64'h1_0000_0000 + 64'd25 * x) / (64'd50 * x);
			y = 64'd65536 - q;
		end else begin
			y = x;
		end
		return encode_srgb(y);
	endfunction

	task automatic report(input string what, input out_pixel_t got, input out_pixel_t want);
		$display("mismatch %s: got %02h %02h %02h want %02h %02h %02h", what,
			got.red_byte, got.green_byte, got.blue_byte,
			want.red_byte, want.green_byte, want.blue_byte);
		errors++;
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [GAIN_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_FLOAT_INPUT) float_mode = val[0];
		else gain = val;
	endtask

	task automatic send_pixel(input in_pixel_t pix, input bit typed, input logic [7:0] byte_all);
		out_pixel_t want;
		if ($urandom_range(99) < idle_in) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_in);
		end
		in_valid <= 1'b1;
		in_data <= pix;
		do @(posedge clk); while (!in_ready);
		if (typed) begin
			want = '{byte_all, byte_all, byte_all};
		end else begin
			want.red_byte = map_channel(pix.red_code);
			want.green_byte = map_channel(pix.green_code);
			want.blue_byte = map_channel(pix.blue_code);
		end
		pending_pixels.push_back(want);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [15:0] random_code();
		if ($urandom_range(9) < 7)
			return {1'b0, 5'($urandom_range(30)), 10'($urandom)};
		return 16'($urandom);
	endfunction

	// result side: random stall, compare against the oldest expected pixel
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= idle_out);
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0)
				report("unexpected transaction", out_data, '0);
			else if (out_data != pending_pixels[0]) begin
				report("pixel", out_data, pending_pixels[0]);
				void'(pending_pixels.pop_front());
			end else
				void'(pending_pixels.pop_front());
		end
	end

	initial begin
		#20_000_000;
		$display("[hdr_half_float_to_srgb8_pixel] ERROR");
		$finish;
	end

	initial begin
		logic [GAIN_W-1:0] phase_gain[6];
		logic              phase_float[6];
		phase_gain = '{17'd0, 17'd26214, 17'd65536, 17'd1, 17'd0, 17'd26214};
		phase_float = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
		phase_gain[4] = 17'($urandom_range(65536));
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_pixel('{directed[i].r, directed[i].g, directed[i].b},
				directed[i].typed, directed[i].byte_all);
		drain();

		for (int p = 0; p < 6; p++) begin
			idle_in = p < 2 ? 21 : (p < 4 ? 88 : 0);
			idle_out = p < 2 ? 88 : (p < 4 ? 21 : 0);
			write_reg(CFG_FLOAT_INPUT, 17'(phase_float[p]));
			write_reg(CFG_WHITE_GAIN, phase_gain[p]);
			repeat (130) begin
				if (float_mode)
					send_pixel('{random_code(), random_code(), random_code()}, 1'b0, 8'd0);
				else
					send_pixel('{16'($urandom), 16'($urandom), 16'($urandom)}, 1'b0, 8'd0);
			end
			drain();
		end

		if (errors == 0)
			$display("[hdr_half_float_to_srgb8_pixel] OK");
		else
			$display("[hdr_half_float_to_srgb8_pixel] ERROR");
		$finish;
	end

endmodule
